// ----- sv/ogtu_pkg.sv -----
// Package with payload types, command and status codes and controller states.
`timescale 1ns / 1ps
`default_nettype none
package ogtu_pkg;

  typedef enum logic [2:0] {
    CMD_APPLY  = 3'd0,
    CMD_FINISH = 3'd1,
    CMD_LOAD   = 3'd2,
    CMD_SET    = 3'd3,
    CMD_READ   = 3'd4,
    CMD_BOX    = 3'd5,
    CMD_RSVD6  = 3'd6,
    CMD_RSVD7  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_KNOWN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL,
    S_TABLE,
    S_FIN_RD,
    S_FIN_WR,
    S_OUT
  } state_e;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic [14:0]        table_index;
    logic [15:0]        new_value;
  } in_t;

  typedef struct packed {
    logic        updated;
    logic [1:0]  status;
    logic [15:0] cell_value;
    logic        known;
    logic [7:0]  box_min_x;
    logic [7:0]  box_min_y;
    logic [8:0]  box_size_x;
    logic [8:0]  box_size_y;
  } out_t;

endpackage
`default_nettype wire

// ----- sv/occupancy_grid_table_update.sv -----
// Top level of the occupancy grid table update block.
// Command flow: apply, set and read of an in-range cell go through a cell read, a table read
// or cell check, then the result; other commands go from the cell read to the result; finish
// reads and writes back each recorded cell before the result. One command at a time: the next
// transfer is taken in the cycle after the result transfer; an apply makes two dependent reads.
// After reset a clearing pass writes the unknown value to all GRID_SIDE*GRID_SIDE cells,
// one cell a cycle with the input stalled; the size registers reset to 256 by 256.
`timescale 1ns / 1ps
`default_nettype none
module occupancy_grid_table_update #(
  parameter int GRID_SIDE     = 256,
  parameter int UPDATE_MARKER = 32768,
  parameter int UNKNOWN_VALUE = 0,
  parameter int LIST_DEPTH    = 4096
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire ogtu_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ogtu_pkg::out_t      out_data_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire                 cfg_index_i,
  input  wire [8:0]           cfg_data_i
);

  localparam int SW   = $clog2(GRID_SIDE);
  localparam int SW1  = SW + 1;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW   = $clog2(CELLS);
  localparam int TW   = $clog2(UPDATE_MARKER);
  localparam int LW   = $clog2(LIST_DEPTH);
  localparam logic [15:0] MARK = 16'(UPDATE_MARKER);
  localparam logic [15:0] UNK  = 16'(UNKNOWN_VALUE);

  // Storage: grid, update table and touched list, each one read port.
  logic [15:0] grid_mem [CELLS];
  logic [15:0] tab_mem [UPDATE_MARKER];
  logic [AW-1:0] list_mem [LIST_DEPTH];

  ogtu_pkg::state_e state_q, state_d;
  ogtu_pkg::in_t cmd_q;
  ogtu_pkg::out_t res_q, res_d;
  logic [8:0] wid_q, hei_q;
  logic [AW:0] clr_q;
  logic [LW:0] cnt_q, cnt_d, fin_q, fin_d;
  logic bempty_q, bempty_d;
  logic [SW-1:0] lox_q, loy_q, hix_q, hiy_q, lox_d, loy_d, hix_d, hiy_d;
  logic [15:0] grid_rd, tab_rd;
  logic [AW-1:0] addr_q, grid_ra;
  logic [AW-1:0] list_rd;
  logic grid_we; logic [AW-1:0] grid_wa; logic [15:0] grid_wd;
  logic [SW1-1:0] w_eff, h_eff;
  logic in_range;
  logic [AW-1:0] flat;
  logic [SW-1:0] ux, uy;

  // One-cycle flags for the grid write and the box update that follow a read.
  logic apply_wr_q, ext_q;
  logic set_ok;

  // Register values above the grid side saturate to the grid side.
  assign w_eff = (32'(wid_q) > GRID_SIDE) ? SW1'(GRID_SIDE) : SW1'(wid_q);
  assign h_eff = (32'(hei_q) > GRID_SIDE) ? SW1'(GRID_SIDE) : SW1'(hei_q);
  assign ux = cmd_q.cell_x[SW-1:0];
  assign uy = cmd_q.cell_y[SW-1:0];
  assign in_range = !cmd_q.cell_x[15] && !cmd_q.cell_y[15]
                  && (32'(cmd_q.cell_x) < 32'(w_eff))
                  && (32'(cmd_q.cell_y) < 32'(h_eff));
  assign flat = AW'(32'(w_eff) * 32'(uy) + 32'(ux));

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= 9'd256;
      hei_q <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ogtu_pkg::CFG_WIDTH:  wid_q <= cfg_data_i;
        ogtu_pkg::CFG_HEIGHT: hei_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[grid_wa] <= grid_wd;
    grid_rd <= grid_mem[grid_ra];
    tab_rd <= tab_mem[grid_rd[TW-1:0]];
    if (state_q == ogtu_pkg::S_CELL && cmd_q.command == ogtu_pkg::CMD_LOAD
        && (32'(cmd_q.table_index) < UPDATE_MARKER))
      tab_mem[cmd_q.table_index[TW-1:0]] <= cmd_q.new_value;
    if (state_q == ogtu_pkg::S_TABLE && cmd_q.command == ogtu_pkg::CMD_APPLY
        && (cnt_d != cnt_q))
      list_mem[cnt_q[LW-1:0]] <= addr_q;
    list_rd <= list_mem[fin_d[LW-1:0]];
  end

  assign in_stall_o  = (state_q != ogtu_pkg::S_IDLE);
  assign out_valid_o = (state_q == ogtu_pkg::S_OUT);
  assign out_data_o  = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ogtu_pkg::S_CLEAR: if (clr_q == (AW+1)'(CELLS - 1)) state_d = ogtu_pkg::S_IDLE;
      ogtu_pkg::S_IDLE:  if (in_valid_i) state_d = ogtu_pkg::S_CELL;
      ogtu_pkg::S_CELL:  state_d = (in_range && (cmd_q.command == ogtu_pkg::CMD_APPLY
                                   || cmd_q.command == ogtu_pkg::CMD_SET
                                   || cmd_q.command == ogtu_pkg::CMD_READ))
                                   ? ogtu_pkg::S_TABLE
                                   : (cmd_q.command == ogtu_pkg::CMD_FINISH)
                                   ? ogtu_pkg::S_FIN_RD : ogtu_pkg::S_OUT;
      ogtu_pkg::S_TABLE: state_d = ogtu_pkg::S_OUT;
      ogtu_pkg::S_FIN_RD: state_d = (fin_q >= cnt_q) ? ogtu_pkg::S_OUT : ogtu_pkg::S_FIN_WR;
      ogtu_pkg::S_FIN_WR: state_d = ogtu_pkg::S_FIN_RD;
      ogtu_pkg::S_OUT:   if (!out_stall_i) state_d = ogtu_pkg::S_IDLE;
      default:           state_d = ogtu_pkg::S_IDLE;
    endcase
  end

  // Grid read address: the command's cell, or the next finish entry.
  always_comb begin
    grid_ra = flat;
    if (state_q == ogtu_pkg::S_FIN_RD) grid_ra = list_rd;
  end

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q; fin_d = fin_q; bempty_d = bempty_q;
    lox_d = lox_q; loy_d = loy_q; hix_d = hix_q; hiy_d = hiy_q;
    grid_we = 1'b0; grid_wa = addr_q; grid_wd = UNK;
    if (state_q == ogtu_pkg::S_CLEAR) begin
      grid_we = 1'b1; grid_wa = clr_q[AW-1:0];
    end
    unique case (state_q)
      ogtu_pkg::S_CELL: begin
        res_d = '0;
        fin_d = '0;
        unique case (cmd_q.command)
          ogtu_pkg::CMD_APPLY: if (!in_range) res_d.status = ogtu_pkg::ST_RANGE;
          ogtu_pkg::CMD_LOAD: if (32'(cmd_q.table_index) >= UPDATE_MARKER)
                                res_d.status = ogtu_pkg::ST_RANGE;
          ogtu_pkg::CMD_SET, ogtu_pkg::CMD_READ:
            if (!in_range) res_d.status = ogtu_pkg::ST_RANGE;
          ogtu_pkg::CMD_BOX: begin
            if (bempty_q) begin
              res_d.box_size_x = 9'd1; res_d.box_size_y = 9'd1;
            end else begin
              res_d.box_min_x = 8'(lox_q); res_d.box_min_y = 8'(loy_q);
              res_d.box_size_x = 9'(32'(hix_q) - 32'(lox_q) + 1);
              res_d.box_size_y = 9'(32'(hiy_q) - 32'(loy_q) + 1);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // Apply, read and set see the cell word in S_TABLE, the state after S_CELL.
    if (state_q == ogtu_pkg::S_TABLE && cmd_q.command == ogtu_pkg::CMD_APPLY) begin
      if (grid_rd >= MARK) begin
      end else if (32'(cnt_q) >= LIST_DEPTH) begin
        res_d.status = ogtu_pkg::ST_FULL;
      end else begin
        cnt_d = cnt_q + 1'b1;
        res_d.updated = 1'b1;
      end
    end
    if (state_q == ogtu_pkg::S_FIN_RD) begin
      fin_d = fin_q + 1'b1;
      if (fin_q >= cnt_q) cnt_d = '0;
    end
    if (state_q == ogtu_pkg::S_FIN_WR && grid_rd >= MARK) begin
      grid_we = 1'b1; grid_wa = addr_q; grid_wd = grid_rd - MARK;
    end
    if (ext_q) begin
      if (bempty_q) begin
        lox_d = ux; hix_d = ux; loy_d = uy; hiy_d = uy; bempty_d = 1'b0;
      end else begin
        if (ux < lox_q) lox_d = ux;
        if (uy < loy_q) loy_d = uy;
        if (ux > hix_q) hix_d = ux;
        if (uy > hiy_q) hiy_d = uy;
      end
    end
    if (state_q == ogtu_pkg::S_TABLE && cmd_q.command == ogtu_pkg::CMD_READ) begin
      res_d.cell_value = grid_rd;
      res_d.known = (grid_rd != UNK);
    end
    if (state_q == ogtu_pkg::S_TABLE && cmd_q.command == ogtu_pkg::CMD_SET) begin
      if (grid_rd != UNK) res_d.status = ogtu_pkg::ST_KNOWN;
      else begin
        grid_we = 1'b1; grid_wd = cmd_q.new_value;
      end
    end
    if (apply_wr_q) begin
      grid_we = 1'b1; grid_wd = tab_rd;
    end
  end

  assign set_ok = state_q == ogtu_pkg::S_TABLE && cmd_q.command == ogtu_pkg::CMD_SET
                  && grid_rd == UNK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ogtu_pkg::S_CLEAR;
      clr_q <= '0; cnt_q <= '0; fin_q <= '0; bempty_q <= 1'b1;
      lox_q <= '0; loy_q <= '0; hix_q <= '0; hiy_q <= '0;
      apply_wr_q <= 1'b0; ext_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ogtu_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
      cnt_q <= cnt_d; fin_q <= fin_d; bempty_q <= bempty_d;
      lox_q <= lox_d; loy_q <= loy_d; hix_q <= hix_d; hiy_q <= hiy_d;
      apply_wr_q <= (state_q == ogtu_pkg::S_TABLE) && (cnt_d != cnt_q);
      ext_q <= ((state_q == ogtu_pkg::S_TABLE) && (cnt_d != cnt_q)) || set_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ogtu_pkg::S_IDLE && in_valid_i) cmd_q <= in_data_i;
    res_q <= res_d;
    if (state_q == ogtu_pkg::S_CELL) addr_q <= flat;
    if (state_q == ogtu_pkg::S_FIN_RD) addr_q <= list_rd;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= LIST_DEPTH)
    else $error("touched count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bempty_q |-> (lox_q <= hix_q) && (loy_q <= hiy_q))
    else $error("box corners crossed");

endmodule
`default_nettype wire
